// File: rtl/core/pnc_pkg.sv
`default_nettype none
package pnc_pkg;

	// Default number of stack entries
	localparam int unsigned STACK_DEPTH_DEFAULT = 64;

	// Opener and closer letter ranges
	localparam logic [7:0] CH_OPEN_FIRST  = 8'h61;
	localparam logic [7:0] CH_OPEN_LAST   = 8'h64;
	localparam logic [7:0] PAIR_OFFSET    = 8'd12;
	localparam logic [7:0] CH_CLOSE_FIRST = CH_OPEN_FIRST + PAIR_OFFSET;
	localparam logic [7:0] CH_CLOSE_LAST  = CH_OPEN_LAST + PAIR_OFFSET;

	// Word status codes
	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_UNCLOSED = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage
`default_nettype wire

// File: rtl/core/pnc_item_if.sv
`default_nettype none
interface pnc_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last_in_word;

	modport source (output valid, output character, output last_in_word, input ready);
	modport sink   (input valid, input character, input last_in_word, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pnc_result_if.sv
`default_nettype none
interface pnc_result_if;
	logic       valid;
	logic       ready;
	logic       word_valid;
	logic [1:0] word_status;

	modport source (output valid, output word_valid, output word_status, input ready);
	modport sink   (input valid, input word_valid, input word_status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/paired_letter_nesting_checker.sv
`default_nettype none
// Nesting checker for words over the letter pairs a/m, b/n, c/o and d/p. It takes one
// character per cycle on the item channel, sustained, and returns one result in the cycle
// after the character flagged last_in_word is transferred; other characters give no
// result. The character rate is set by the opener stack: a register holds the top entry
// and the memory is read every cycle at the entry just below it, so a pop in any cycle
// finds its new top ready. The stack memory needs no clearing pass after reset. The
// item channel stalls only while a result waits and the result channel is not ready.
// A closer on an empty stack is ignored; a mismatched closer or a push onto a full
// stack rejects the rest of the word. STACK_DEPTH sets the number of stack entries.
module paired_letter_nesting_checker #(
	parameter int unsigned STACK_DEPTH = pnc_pkg::STACK_DEPTH_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pnc_item_if.sink      items,
	pnc_result_if.source  results
);
	import pnc_pkg::*;

	localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

	logic [LVL_W-1:0]  level_q, level_nxt, level_d;
	logic              rejected_q, overflowed_q, rej_nxt, ovf_nxt;
	logic [1:0]        top_q, below_q;
	logic [1:0]        stack_mem [STACK_DEPTH];
	logic              res_valid_q, word_valid_q;
	status_t           status_q, status_nxt;

	logic              accept, skip, full, empty;
	logic              is_open, is_close, push, pop, close_act;
	logic [7:0]        open_off, close_off;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr, raddr;

	// Accept while the result slot is free or draining
	assign items.ready = !res_valid_q || results.ready;
	assign accept      = items.valid && items.ready;

	// Classify the character
	assign is_open   = (items.character >= CH_OPEN_FIRST) && (items.character <= CH_OPEN_LAST);
	assign is_close  = (items.character >= CH_CLOSE_FIRST) && (items.character <= CH_CLOSE_LAST);
	assign open_off  = items.character - CH_OPEN_FIRST;
	assign close_off = items.character - CH_CLOSE_FIRST;

	assign skip  = rejected_q || overflowed_q;
	assign full  = (level_q == LVL_W'(STACK_DEPTH));
	assign empty = (level_q == '0);

	// Stack operation for this transfer
	assign push      = accept && !skip && is_open && !full;
	assign close_act = accept && !skip && is_close && !empty;
	assign pop       = close_act && (close_off[1:0] == top_q);

	always_comb begin
		rej_nxt = rejected_q || (close_act && (close_off[1:0] != top_q));
		ovf_nxt = overflowed_q || (accept && !skip && is_open && full);
		if (push) begin
			level_nxt = level_q + LVL_W'(1);
		end else if (pop) begin
			level_nxt = level_q - LVL_W'(1);
		end else begin
			level_nxt = level_q;
		end
	end

	// Word status after this character
	always_comb begin
		priority if (rej_nxt) begin
			status_nxt = ST_MISMATCH;
		end else if (ovf_nxt) begin
			status_nxt = ST_OVERFLOW;
		end else if (level_nxt != '0) begin
			status_nxt = ST_UNCLOSED;
		end else begin
			status_nxt = ST_VALID;
		end
	end

	// Clear the word state at the word end
	assign level_d = (accept && items.last_in_word) ? '0 : level_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			rejected_q   <= 1'b0;
			overflowed_q <= 1'b0;
		end else if (accept) begin
			level_q      <= level_d;
			rejected_q   <= rej_nxt && !items.last_in_word;
			overflowed_q <= ovf_nxt && !items.last_in_word;
		end
	end

	// Hold the top entry in a register
	always_ff @(posedge clk) begin
		if (push) begin
			top_q <= open_off[1:0];
		end else if (pop) begin
			top_q <= below_q;
		end
	end

	// Spill the old top on a push, read the entry below the new top
	assign mem_we = push && !empty;
	assign waddr  = ADDR_W'(level_q - LVL_W'(1));
	assign raddr  = ADDR_W'(level_d - LVL_W'(2));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[waddr] <= top_q;
		end
		if (mem_we && (waddr == raddr)) begin
			below_q <= top_q;
		end else begin
			below_q <= stack_mem[raddr];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && items.last_in_word) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && items.last_in_word) begin
			word_valid_q <= (status_nxt == ST_VALID);
			status_q     <= status_nxt;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.word_valid  = word_valid_q;
	assign results.word_status = status_q;

endmodule
`default_nettype wire

// File: rtl/core/pnc_checker.sv
`default_nettype none
module pnc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_ready,
	input wire logic       item_last,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_word_valid,
	input wire logic [1:0] res_word_status
);
	import pnc_pkg::*;

	// Hold a waiting result until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word_status)
			&& $stable(res_word_valid))
		else $error("result dropped or changed while stalled");

	// A new result follows a transfer of a last character
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid && item_ready && item_last))
		else $error("result without a word end");

	// The valid flag agrees with the status code
	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word_valid == (res_word_status == ST_VALID)))
		else $error("word_valid disagrees with word_status");

	// Take characters whenever the result slot is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("item channel stalled with empty result slot");

endmodule

bind paired_letter_nesting_checker pnc_checker u_pnc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (items.valid),
	.item_ready      (items.ready),
	.item_last       (items.last_in_word),
	.res_valid       (results.valid),
	.res_ready       (results.ready),
	.res_word_valid  (results.word_valid),
	.res_word_status (results.word_status)
);
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pnc_pkg::*;

	localparam int unsigned DEPTH = STACK_DEPTH_DEFAULT;
	localparam int NUM_CHARS = 1700;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct {
		logic    word_valid;
		status_t word_status;
	} verdict_t;

	logic clk;
	logic arst_n;

	pnc_item_if   item_ch();
	pnc_result_if result_ch();

	paired_letter_nesting_checker #(.STACK_DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_ch),
		.results(result_ch)
	);

	// characters waiting to be sent, and verdicts waiting to come back
	char_item_t pending_chars[$];
	verdict_t   expected_verdicts[$];
	logic [7:0] word_buf[$];
	int         errors;

	// shadow copy of the nesting state
	logic [1:0]  opener_codes[DEPTH];
	int unsigned stack_level;
	logic        word_rejected;
	logic        word_overflowed;

	// driver and receiver pacing
	int unsigned send_gap;
	int unsigned take_stall;
	logic        send_burst;
	logic        take_burst;
	logic        char_taken;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_OPEN_FIRST && b <= CH_OPEN_LAST) ||
			(b >= CH_CLOSE_FIRST && b <= CH_CLOSE_LAST);
	endfunction

	// mostly zero, some short, a few long
	function automatic int unsigned pick_gap(input logic burst);
		int unsigned r;
		if (burst) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	// any byte that is neither an opener nor a closer
	function automatic logic [7:0] pick_filler();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (is_letter(b)) begin
			b = b ^ 8'h80;
		end
		return b;
	endfunction

	// advance the nesting state by one character; queue a verdict at word end
	function automatic void nest_step(input logic [7:0] ch, input logic last);
		verdict_t v;
		logic [7:0] want_close;
		if (!word_rejected && !word_overflowed) begin
			if (ch >= CH_OPEN_FIRST && ch <= CH_OPEN_LAST) begin
				if (stack_level >= DEPTH) begin
					word_overflowed = 1'b1;
				end else begin
					opener_codes[stack_level] = 2'(ch - CH_OPEN_FIRST);
					stack_level++;
				end
			end else if (ch >= CH_CLOSE_FIRST && ch <= CH_CLOSE_LAST && stack_level > 0) begin
				want_close = CH_CLOSE_FIRST + 8'(opener_codes[stack_level - 1]);
				if (ch == want_close) begin
					stack_level--;
				end else begin
					word_rejected = 1'b1;
				end
			end
		end
		if (last) begin
			if (word_rejected) begin
				v.word_status = ST_MISMATCH;
			end else if (word_overflowed) begin
				v.word_status = ST_OVERFLOW;
			end else if (stack_level != 0) begin
				v.word_status = ST_UNCLOSED;
			end else begin
				v.word_status = ST_VALID;
			end
			v.word_valid = (v.word_status == ST_VALID);
			expected_verdicts.push_back(v);
			stack_level = 0;
			word_rejected = 1'b0;
			word_overflowed = 1'b0;
		end
	endfunction

	// move the word buffer into the send queue, flagging its final character
	task automatic emit_word();
		char_item_t it;
		if (word_buf.size() == 0) begin
			word_buf.push_back(pick_filler());
		end
		foreach (word_buf[i]) begin
			it.ch = word_buf[i];
			it.last = (i == word_buf.size() - 1);
			pending_chars.push_back(it);
		end
		word_buf.delete();
	endtask

	task automatic emit_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			word_buf.push_back(s[i]);
		end
		emit_word();
	endtask

	// well-nested letters, openers taken with the given bias, filler mixed in
	task automatic build_balanced(input int pairs, input int max_depth, input int bias,
		input int filler_pct);
		logic [1:0] open_q[$];
		logic [1:0] k;
		int left;
		left = pairs;
		while (left > 0 || open_q.size() > 0) begin
			if ($urandom_range(0, 99) < filler_pct) begin
				word_buf.push_back(pick_filler());
			end
			if (left > 0 && open_q.size() < max_depth &&
				(open_q.size() == 0 || $urandom_range(0, 99) < bias)) begin
				k = 2'($urandom_range(0, 3));
				open_q.push_back(k);
				word_buf.push_back(CH_OPEN_FIRST + 8'(k));
				left--;
			end else begin
				k = open_q.pop_back();
				word_buf.push_back(CH_CLOSE_FIRST + 8'(k));
			end
		end
	endtask

	// swap one closer for a wrong one
	task automatic break_closer();
		int idx[$];
		int pick;
		logic [7:0] c;
		foreach (word_buf[i]) begin
			if (word_buf[i] >= CH_CLOSE_FIRST && word_buf[i] <= CH_CLOSE_LAST) begin
				idx.push_back(i);
			end
		end
		if (idx.size() > 0) begin
			pick = idx[$urandom_range(0, idx.size() - 1)];
			c = word_buf[pick] - CH_CLOSE_FIRST;
			word_buf[pick] = CH_CLOSE_FIRST + ((c + 8'($urandom_range(1, 3))) & 8'h03);
		end
	endtask

	task automatic random_word();
		int unsigned r;
		int pairs;
		r = $urandom_range(0, 99);
		pairs = $urandom_range(1, 6);
		if (r < 4) begin
			// nest deep, up to a full stack
			build_balanced(DEPTH, DEPTH, 95 + $urandom_range(0, 5), 0);
		end else if (r < 45) begin
			build_balanced(pairs, $urandom_range(1, 8), 60, 15);
		end else if (r < 60) begin
			build_balanced(pairs, $urandom_range(1, 8), 60, 10);
			break_closer();
			repeat ($urandom_range(0, 3)) word_buf.push_back(CH_CLOSE_FIRST +
				8'($urandom_range(0, 3)));
		end else if (r < 72) begin
			build_balanced(pairs, $urandom_range(1, 8), 60, 10);
			if ($urandom_range(0, 1)) begin
				repeat ($urandom_range(1, 3)) word_buf.push_back(CH_OPEN_FIRST +
					8'($urandom_range(0, 3)));
			end else begin
				word_buf.insert($urandom_range(0, word_buf.size()),
					CH_OPEN_FIRST + 8'($urandom_range(0, 3)));
			end
		end else if (r < 80) begin
			// closers with nothing open are dropped
			repeat ($urandom_range(1, 3)) word_buf.push_back(CH_CLOSE_FIRST +
				8'($urandom_range(0, 3)));
			build_balanced(pairs, 4, 50, 10);
		end else if (r < 98) begin
			repeat ($urandom_range(1, 8)) word_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			// push past a full stack, then trailing bytes that must be skipped
			repeat (DEPTH + $urandom_range(1, 3)) word_buf.push_back(CH_OPEN_FIRST +
				8'($urandom_range(0, 3)));
			repeat ($urandom_range(0, 6)) word_buf.push_back(8'($urandom_range(0, 255)));
		end
		emit_word();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// drive characters at the falling edge; hold until transferred
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0) begin
				send_burst = !send_burst;
			end
			if (!item_ch.valid || char_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					item_ch.valid <= 1'b1;
					item_ch.character <= pending_chars[0].ch;
					item_ch.last_in_word <= pending_chars[0].last;
					send_gap = pick_gap(send_burst);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
			char_taken = 1'b0;
		end
	end

	// throttle the result channel
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0) begin
				take_burst = !take_burst;
			end
			if (take_stall > 0) begin
				take_stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (!take_burst && $urandom_range(0, 3) == 0) begin
					take_stall = pick_gap(1'b0);
				end
			end
		end
	end

	// predict on every character transfer
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			nest_step(item_ch.character, item_ch.last_in_word);
			void'(pending_chars.pop_front());
			char_taken = 1'b1;
		end
	end

	// check every result transfer against the oldest verdict
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result word_valid %0d word_status %0d", $time,
					result_ch.word_valid, result_ch.word_status);
				errors++;
			end else begin
				v = expected_verdicts.pop_front();
				if (result_ch.word_valid !== v.word_valid) begin
					$display("%0t: word_valid expected %0d got %0d", $time,
						v.word_valid, result_ch.word_valid);
					errors++;
				end
				if (result_ch.word_status !== v.word_status) begin
					$display("%0t: word_status expected %0d got %0d", $time,
						v.word_status, result_ch.word_status);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("FAIL paired_letter_nesting_checker");
		$finish;
	end

	// stimulus and end of run
	initial begin
		errors = 0;
		stack_level = 0;
		word_rejected = 1'b0;
		word_overflowed = 1'b0;
		send_gap = 0;
		take_stall = 0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		char_taken = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.character = 8'h00;
		item_ch.last_in_word = 1'b0;
		result_ch.ready = 1'b0;

		// each pair, unclosed, mismatch, closer on empty stack, boundary bytes
		emit_text("am");
		emit_text("bn");
		emit_text("co");
		emit_text("dp");
		emit_text("a");
		emit_text("an");
		emit_text("anam");
		emit_text("m");
		emit_text("pdp");
		emit_text("abcdponm");
		// bytes just outside the opener and closer ranges
		word_buf.push_back(CH_OPEN_FIRST - 8'd1);
		word_buf.push_back(CH_OPEN_LAST + 8'd1);
		word_buf.push_back(CH_CLOSE_FIRST - 8'd1);
		word_buf.push_back(CH_CLOSE_LAST + 8'd1);
		emit_word();
		word_buf.push_back(CH_OPEN_FIRST);
		word_buf.push_back(8'h00);
		word_buf.push_back(8'hFF);
		word_buf.push_back(8'h7F);
		word_buf.push_back(8'h80);
		word_buf.push_back(CH_CLOSE_FIRST);
		emit_word();
		// full stack closed again, full stack left open, push on full stack
		build_balanced(DEPTH, DEPTH, 100, 0);
		emit_word();
		repeat (DEPTH) word_buf.push_back(CH_OPEN_FIRST + 8'd1);
		emit_word();
		repeat (DEPTH + 1) word_buf.push_back(CH_OPEN_LAST);
		word_buf.push_back(CH_CLOSE_LAST);
		emit_word();

		while (pending_chars.size() < NUM_CHARS) begin
			random_word();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() > 0) @(posedge clk);
		while (expected_verdicts.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("PASS paired_letter_nesting_checker");
		end else begin
			$display("FAIL paired_letter_nesting_checker");
		end
		$finish;
	end

endmodule
`default_nettype wire
